// ===== src/cfdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunk frustum distance culler: shared package
// Widths, register indexes and the item types carried between pipeline stages.
// ----------------------------------------------------------------------------
package cfdc_pkg;

   localparam int CHUNK_SIZE   = 16;
   localparam int CHUNK_SHIFT  = $clog2(CHUNK_SIZE);
   localparam int WORLD_LAYERS = 16;

   localparam int AXES    = 3;
   localparam int PLANES  = 5;
   localparam int CHUNK_W = 17;
   localparam int BOX_W   = 5;
   localparam int SLOT_W  = 32;
   localparam int CAM_W   = 21;
   localparam int FRAC_W  = 8;
   localparam int VD_W    = 11;
   localparam int COEF_W  = 16;
   localparam int PLANE_W = 64;
   localparam int CAMB_W  = AXES * CAM_W;
   localparam int CAMF_W  = AXES * FRAC_W;

   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;

   localparam int OFS_W   = CAM_W + 2;
   localparam int REL_W   = OFS_W + FRAC_W + 1;
   localparam int GRID_W  = CHUNK_W + 1;
   localparam int RAD_W   = VD_W - CHUNK_SHIFT + 2;
   localparam int DIST_W  = REL_W - 2;
   localparam int SQ_W    = 2 * DIST_W;
   localparam int LIM_W   = 2 * (VD_W + FRAC_W);
   localparam int PROD_W  = COEF_W + REL_W;
   localparam int PSUM_W  = PROD_W + 2;
   localparam int D_SHIFT = 18;

   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_LEFT      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_RIGHT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_BOTTOM    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_TOP       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_NEAR      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_BLOCK    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_FRACTION = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_DISTANCE   = 3'd7;

   localparam logic [VD_W-1:0] VIEW_DISTANCE_RST = 11'd256;

   typedef struct packed {
      logic [PLANES-1:0][PLANE_W-1:0] planes;
      logic [CAMB_W-1:0]              camera_block;
      logic [CAMF_W-1:0]              camera_fraction;
      logic [VD_W-1:0]                view_distance;
   } cfg_type;

   typedef struct packed {
      logic [SLOT_W-1:0]            draw_slot;
      logic                         drawable;
      logic [AXES-1:0][BOX_W-1:0]   box_max;
      logic [AXES-1:0][BOX_W-1:0]   box_min;
      logic [AXES-1:0][CHUNK_W-1:0] chunk;
   } req_item_type;

   typedef struct packed {
      logic [SLOT_W-1:0]            draw_slot;
      logic                         drawable;
      logic                         in_grid;
      logic [AXES-1:0][BOX_W-1:0] box_max;
      logic [AXES-1:0][BOX_W-1:0] box_min;
      logic [AXES-1:0][REL_W-1:0] rel;
   } front_type;

   typedef struct packed {
      logic [SLOT_W-1:0]                      draw_slot;
      logic                                   drawable;
      logic                                   in_grid;
      logic [1:0][DIST_W-1:0]                 hdist;
      logic [PLANES-1:0][AXES-1:0][REL_W-1:0] corner;
   } corner_type;

   typedef struct packed {
      logic [SLOT_W-1:0]                       draw_slot;
      logic                                    drawable;
      logic                                    in_grid;
      logic [LIM_W-1:0]                        lim_sq;
      logic [1:0][SQ_W-1:0]                    dist_sq;
      logic [PLANES-1:0][AXES-1:0][PROD_W-1:0] prod;
   } mult_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_out;
      logic              in_range;
      logic              draw;
   } rsp_item_type;

endpackage

// ===== src/cfdc_front.sv =====
// ----------------------------------------------------------------------------
// Chunk frustum distance culler: front stage
// Chunk origin relative to the camera in 1/256 block, and the grid and layer
// test against the camera chunk.
// ----------------------------------------------------------------------------
module cfdc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  cfdc_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cfdc_pkg::req_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cfdc_pkg::front_type    out_item
);
   import cfdc_pkg::*;

   logic                     valid_ff;
   front_type                item_ff;
   front_type                item_in;
   logic signed [CAM_W-1:0]  cam [AXES];
   logic signed [OFS_W-1:0]  ofs [AXES];
   logic signed [REL_W-1:0]  rel [AXES];
   logic signed [GRID_W-1:0] grid_ofs [2];
   logic [1:0]               in_axis;
   logic [VD_W:0]            vd_round;
   logic [RAD_W-1:0]         radius;
   logic signed [GRID_W-1:0] rad_s;
   logic                     in_layer;

   for (genvar k = 0; k < AXES; k++) begin : g_axis
      assign cam[k] = $signed(cfg.camera_block[k*CAM_W +: CAM_W]);
      assign ofs[k] = (OFS_W'($signed(in_item.chunk[k])) <<< CHUNK_SHIFT) - OFS_W'(cam[k]);
      assign rel[k] = (REL_W'(ofs[k]) <<< FRAC_W)
                    - REL_W'({1'b0, cfg.camera_fraction[k*FRAC_W +: FRAC_W]});
   end

   assign vd_round = {1'b0, cfg.view_distance} + (VD_W+1)'(CHUNK_SIZE - 1);
   assign radius   = RAD_W'(vd_round >> CHUNK_SHIFT) + RAD_W'(1);
   assign rad_s    = $signed(GRID_W'(radius));

   for (genvar j = 0; j < 2; j++) begin : g_grid
      assign grid_ofs[j] = GRID_W'($signed(in_item.chunk[2*j]))
                         - GRID_W'(cam[2*j] >>> CHUNK_SHIFT);
      assign in_axis[j]  = (grid_ofs[j] <= rad_s) && (grid_ofs[j] >= -rad_s);
   end

   assign in_layer = !in_item.chunk[1][CHUNK_W-1]
                  && (in_item.chunk[1] < CHUNK_W'(WORLD_LAYERS));

   always_comb begin
      item_in.draw_slot = in_item.draw_slot;
      item_in.drawable  = in_item.drawable;
      item_in.in_grid   = &in_axis && in_layer;
      item_in.box_max   = in_item.box_max;
      item_in.box_min   = in_item.box_min;
      for (int k = 0; k < AXES; k++) begin
         item_in.rel[k] = rel[k];
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== src/cfdc_corner.sv =====
// ----------------------------------------------------------------------------
// Chunk frustum distance culler: corner stage
// Horizontal distance to the chunk column and the positive-vertex corner of
// the content box for each frustum plane.
// ----------------------------------------------------------------------------
module cfdc_corner (
   input  logic                 clock,
   input  logic                 reset,
   input  cfdc_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  cfdc_pkg::front_type   in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cfdc_pkg::corner_type  out_item
);
   import cfdc_pkg::*;

   localparam logic signed [REL_W-1:0] SPAN = REL_W'(CHUNK_SIZE << FRAC_W);

   logic                            valid_ff;
   corner_type                      item_ff;
   corner_type                      item_in;
   logic signed [REL_W-1:0]         rel [AXES];
   logic signed [REL_W-1:0]         lo [AXES];
   logic signed [REL_W-1:0]         hi [AXES];
   logic signed [REL_W-1:0]         far [2];
   logic [DIST_W-1:0]               hdist [2];
   logic [PLANES-1:0][AXES-1:0]     coef_pos;

   for (genvar k = 0; k < AXES; k++) begin : g_axis
      assign rel[k] = $signed(in_item.rel[k]);
      assign lo[k]  = rel[k] + (REL_W'(in_item.box_min[k]) << FRAC_W);
      assign hi[k]  = rel[k] + (REL_W'(in_item.box_max[k]) << FRAC_W);
   end

   for (genvar j = 0; j < 2; j++) begin : g_dist
      assign far[j]   = -rel[2*j] - SPAN;
      assign hdist[j] = !rel[2*j][REL_W-1] ? DIST_W'(rel[2*j])
                      : (far[j] > 0) ? DIST_W'(far[j]) : '0;
   end

   for (genvar p = 0; p < PLANES; p++) begin : g_plane
      for (genvar k = 0; k < AXES; k++) begin : g_coef
         assign coef_pos[p][k] = !cfg.planes[p][k*COEF_W + COEF_W - 1]
                              && (cfg.planes[p][k*COEF_W +: COEF_W] != '0);
      end
   end

   always_comb begin
      item_in.draw_slot = in_item.draw_slot;
      item_in.drawable  = in_item.drawable;
      item_in.in_grid   = in_item.in_grid;
      for (int j = 0; j < 2; j++) begin
         item_in.hdist[j] = hdist[j];
      end
      for (int p = 0; p < PLANES; p++) begin
         for (int k = 0; k < AXES; k++) begin
            item_in.corner[p][k] = coef_pos[p][k] ? hi[k] : lo[k];
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== src/cfdc_mult.sv =====
// ----------------------------------------------------------------------------
// Chunk frustum distance culler: multiplier stage
// Squares of the horizontal distances, the squared view limit and the fifteen
// plane coefficient products.
// ----------------------------------------------------------------------------
module cfdc_mult (
   input  logic                 clock,
   input  logic                 reset,
   input  cfdc_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  cfdc_pkg::corner_type  in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cfdc_pkg::mult_type    out_item
);
   import cfdc_pkg::*;

   logic                     valid_ff;
   mult_type                 item_ff;
   mult_type                 item_in;
   logic [2*VD_W-1:0]        vd_sq;
   logic [SQ_W-1:0]          dist_sq [2];
   logic signed [PROD_W-1:0] prod [PLANES][AXES];

   assign vd_sq = (2*VD_W)'(cfg.view_distance) * (2*VD_W)'(cfg.view_distance);

   for (genvar j = 0; j < 2; j++) begin : g_dist
      assign dist_sq[j] = in_item.hdist[j] * in_item.hdist[j];
   end

   for (genvar p = 0; p < PLANES; p++) begin : g_plane
      for (genvar k = 0; k < AXES; k++) begin : g_axis
         logic signed [COEF_W-1:0] coef;
         logic signed [REL_W-1:0]  corner;
         assign coef       = $signed(cfg.planes[p][k*COEF_W +: COEF_W]);
         assign corner     = $signed(in_item.corner[p][k]);
         assign prod[p][k] = coef * corner;
      end
   end

   always_comb begin
      item_in.draw_slot = in_item.draw_slot;
      item_in.drawable  = in_item.drawable;
      item_in.in_grid   = in_item.in_grid;
      item_in.lim_sq    = {vd_sq, {(2*FRAC_W){1'b0}}};
      for (int j = 0; j < 2; j++) begin
         item_in.dist_sq[j] = dist_sq[j];
      end
      for (int p = 0; p < PLANES; p++) begin
         for (int k = 0; k < AXES; k++) begin
            item_in.prod[p][k] = prod[p][k];
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== src/cfdc_reduce.sv =====
// ----------------------------------------------------------------------------
// Chunk frustum distance culler: decision stage
// Distance compare, plane sums with the offset term, and the registered
// result item.
// ----------------------------------------------------------------------------
module cfdc_reduce (
   input  logic                   clock,
   input  logic                   reset,
   input  cfdc_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cfdc_pkg::mult_type      in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cfdc_pkg::rsp_item_type  out_item
);
   import cfdc_pkg::*;

   logic                     valid_ff;
   rsp_item_type             item_ff;
   rsp_item_type             item_in;
   logic [SQ_W:0]            dist_sum;
   logic                     in_range;
   logic signed [PSUM_W-1:0] psum [PLANES];
   logic [PLANES-1:0]        pass;

   assign dist_sum = {1'b0, in_item.dist_sq[0]} + {1'b0, in_item.dist_sq[1]};
   assign in_range = in_item.in_grid && (dist_sum <= (SQ_W+1)'(in_item.lim_sq));

   for (genvar p = 0; p < PLANES; p++) begin : g_plane
      logic signed [COEF_W-1:0] offset;
      assign offset  = $signed(cfg.planes[p][PLANE_W-1 -: COEF_W]);
      assign psum[p] = $signed(in_item.prod[p][0]) + $signed(in_item.prod[p][1])
                     + $signed(in_item.prod[p][2]) + (PSUM_W'(offset) <<< D_SHIFT);
      assign pass[p] = !psum[p][PSUM_W-1];
   end

   always_comb begin
      item_in.slot_out = in_item.draw_slot;
      item_in.in_range = in_range;
      item_in.draw     = in_range && in_item.drawable && (&pass);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== src/chunk_frustum_distance_culler.sv =====
// ----------------------------------------------------------------------------
// Chunk frustum distance culler: top level
// Grid, view distance and five-plane frustum test of resident chunks.
// ----------------------------------------------------------------------------
// The block takes one chunk item per clock while req_tready is high and returns
// one result item for each, in order. The four register stages (camera-relative
// origin and grid test, distance and corner select, multipliers, sums and
// compares) follow one another; every stage holds its own item and valid bit,
// so a stall on the result side fills the stages before req_tready drops.
// Configuration writes take effect at once and belong to idle periods; after
// reset all planes are zero, which accept every box, and the view distance is
// 256 blocks.
module chunk_frustum_distance_culler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [cfdc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cfdc_pkg::CSR_W-1:0]          csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // chunk_x, chunk_y, chunk_z, box_min_x, box_min_y, box_min_z,
   // box_max_x, box_max_y, box_max_z, draw_slot
   input  logic [cfdc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // drawable
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // draw, in_range, slot_out
   output logic [cfdc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import cfdc_pkg::*;

   cfg_type      cfg_ff;
   req_item_type req_item;
   front_type    front_item;
   corner_type   corner_item;
   mult_type     mult_item;
   rsp_item_type rsp_item;
   logic         front_valid, front_ready;
   logic         corner_valid, corner_ready;
   logic         mult_valid, mult_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.planes          <= '0;
         cfg_ff.camera_block    <= '0;
         cfg_ff.camera_fraction <= '0;
         cfg_ff.view_distance   <= VIEW_DISTANCE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PLANE_LEFT, CSR_PLANE_RIGHT, CSR_PLANE_BOTTOM, CSR_PLANE_TOP,
            CSR_PLANE_NEAR: begin
               cfg_ff.planes[csr_index] <= csr_wdata;
            end
            CSR_CAMERA_BLOCK: begin
               cfg_ff.camera_block <= csr_wdata[CAMB_W-1:0];
            end
            CSR_CAMERA_FRACTION: begin
               cfg_ff.camera_fraction <= csr_wdata[CAMF_W-1:0];
            end
            CSR_VIEW_DISTANCE: begin
               cfg_ff.view_distance <= csr_wdata[VD_W-1:0];
            end
         endcase
      end
   end

   assign req_item.chunk[0]   = req_tdata[16:0];
   assign req_item.chunk[1]   = req_tdata[33:17];
   assign req_item.chunk[2]   = req_tdata[50:34];
   assign req_item.box_min[0] = req_tdata[55:51];
   assign req_item.box_min[1] = req_tdata[60:56];
   assign req_item.box_min[2] = req_tdata[65:61];
   assign req_item.box_max[0] = req_tdata[70:66];
   assign req_item.box_max[1] = req_tdata[75:71];
   assign req_item.box_max[2] = req_tdata[80:76];
   assign req_item.draw_slot  = req_tdata[112:81];
   assign req_item.drawable   = req_tuser;

   cfdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   cfdc_corner u_corner (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (corner_valid),
      .out_ready (corner_ready),
      .out_item  (corner_item)
   );

   cfdc_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (corner_valid),
      .in_ready  (corner_ready),
      .in_item   (corner_item),
      .out_valid (mult_valid),
      .out_ready (mult_ready),
      .out_item  (mult_item)
   );

   cfdc_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mult_valid),
      .in_ready  (mult_ready),
      .in_item   (mult_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_item);

endmodule

// ===== src/cfdc_checker.sv =====
// ----------------------------------------------------------------------------
// Chunk frustum distance culler: port checker
// Watches the top level's ports and flags result and flow-control slips.
// ----------------------------------------------------------------------------
module cfdc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [cfdc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_draw_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[0] || rsp_tdata[1])
      else $error("draw set on an item out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item present after reset");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty output stage");

endmodule

bind chunk_frustum_distance_culler cfdc_checker u_checker (.*);

// ===== tb/sv/cull_checker.sv =====
// ----------------------------------------------------------------------------
// Chunk culler result checker
// Watches the register port and both streams of the culler, keeps its own copy
// of the camera, view distance and frustum planes, works out the draw decision
// of every accepted chunk and compares it field by field with the result
// stream in order.
// ----------------------------------------------------------------------------
module cull_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [cfdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cfdc_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // chunk_x, chunk_y, chunk_z, box_min_x, box_min_y, box_min_z,
   // box_max_x, box_max_y, box_max_z, draw_slot
   input  logic [cfdc_pkg::REQ_DATA_W-1:0] req_tdata,
   // drawable
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // draw, in_range, slot_out
   input  logic [cfdc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             outstanding,
   output int                             mismatches
);
   import cfdc_pkg::*;

   localparam int BOX_MIN_LSB = AXES * CHUNK_W;
   localparam int BOX_MAX_LSB = BOX_MIN_LSB + AXES * BOX_W;
   localparam int SLOT_LSB    = BOX_MAX_LSB + AXES * BOX_W;

   logic [PLANE_W-1:0] plane_cfg [PLANES];
   logic [CAMB_W-1:0]  cam_block_cfg;
   logic [CAMF_W-1:0]  cam_frac_cfg;
   logic [VD_W-1:0]    view_cfg;

   rsp_item_type expected_verdicts [$];
   int           fail_count = 0;

   function automatic rsp_item_type cull_verdict(input logic [REQ_DATA_W-1:0] data,
                                                 input logic drawable);
      longint       chunk [AXES];
      longint       pos [AXES];
      longint       lo [AXES];
      longint       hi [AXES];
      longint       cam, frac, box, vd, radius, ox, oz, dx, dz, lim, coef, sum;
      logic         grid_ok;
      rsp_item_type v;
      int           k, p;
      for (k = 0; k < AXES; k++) begin
         chunk[k] = $signed(data[k*CHUNK_W +: CHUNK_W]);
         cam      = $signed(cam_block_cfg[k*CAM_W +: CAM_W]);
         frac     = cam_frac_cfg[k*FRAC_W +: FRAC_W];
         pos[k]   = (chunk[k] * CHUNK_SIZE - cam) * 256 - frac;
         if (k == 0) ox = chunk[k] - (cam >>> CHUNK_SHIFT);
         if (k == 2) oz = chunk[k] - (cam >>> CHUNK_SHIFT);
      end
      vd      = view_cfg;
      radius  = (vd + CHUNK_SIZE - 1) / CHUNK_SIZE + 1;
      grid_ok = ox >= -radius && ox <= radius && oz >= -radius && oz <= radius &&
                chunk[1] >= 0 && chunk[1] < WORLD_LAYERS;
      dx = pos[0] > 0 ? pos[0] : 0;
      if (-(pos[0] + CHUNK_SIZE * 256) > dx) dx = -(pos[0] + CHUNK_SIZE * 256);
      dz = pos[2] > 0 ? pos[2] : 0;
      if (-(pos[2] + CHUNK_SIZE * 256) > dz) dz = -(pos[2] + CHUNK_SIZE * 256);
      lim = vd * 256;
      v.in_range = grid_ok && (dx * dx + dz * dz <= lim * lim);
      v.draw     = v.in_range && drawable;
      v.slot_out = data[SLOT_LSB +: SLOT_W];
      if (v.draw) begin
         for (k = 0; k < AXES; k++) begin
            box   = data[BOX_MIN_LSB + k*BOX_W +: BOX_W];
            lo[k] = pos[k] + box * 256;
            box   = data[BOX_MAX_LSB + k*BOX_W +: BOX_W];
            hi[k] = pos[k] + box * 256;
         end
         for (p = 0; p < PLANES; p++) begin
            sum = 0;
            for (k = 0; k < AXES; k++) begin
               coef = $signed(plane_cfg[p][k*COEF_W +: COEF_W]);
               sum += coef * (coef > 0 ? hi[k] : lo[k]);
            end
            coef = $signed(plane_cfg[p][AXES*COEF_W +: COEF_W]);
            sum += coef * (longint'(1) << D_SHIFT);
            if (sum < 0) v.draw = 1'b0;
         end
      end
      return v;
   endfunction

   task automatic report_mismatch(input string field, input longint want, input longint got,
                                  input logic [SLOT_W-1:0] slot);
      $display("cull check: %s expected %0d got %0d (slot %h)", field, want, got, slot);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_item_type got, want;
      int           p;
      if (reset) begin
         expected_verdicts.delete();
         for (p = 0; p < PLANES; p++) plane_cfg[p] = '0;
         cam_block_cfg = '0;
         cam_frac_cfg  = '0;
         view_cfg      = VIEW_DISTANCE_RST;
      end else begin
         if (req_tvalid && req_tready)
            expected_verdicts.insert(expected_verdicts.size(),
                                     cull_verdict(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(rsp_item_type)-1:0];
            if (expected_verdicts.size() == 0) begin
               report_mismatch("result with no chunk pending", 0, 1, got.slot_out);
            end else begin
               want = expected_verdicts.pop_front();
               if (got.draw != want.draw)
                  report_mismatch("draw", want.draw, got.draw, want.slot_out);
               if (got.in_range != want.in_range)
                  report_mismatch("in_range", want.in_range, got.in_range, want.slot_out);
               if (got.slot_out != want.slot_out)
                  report_mismatch("slot_out", want.slot_out, got.slot_out, want.slot_out);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_CAMERA_BLOCK:    cam_block_cfg = csr_wdata[CAMB_W-1:0];
               CSR_CAMERA_FRACTION: cam_frac_cfg  = csr_wdata[CAMF_W-1:0];
               CSR_VIEW_DISTANCE:   view_cfg      = csr_wdata[VD_W-1:0];
               default:             plane_cfg[csr_index] = csr_wdata;
            endcase
         end
      end
      outstanding <= expected_verdicts.size();
      mismatches  <= fail_count;
   end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Chunk culler testbench
// Drives directed edge chunks and then phases of random chunks around a
// camera under several camera, view distance and plane settings, with random
// gaps on both streams and one long result stall; the checker predicts and
// compares every result and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import cfdc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_ITEMS    = 78;

   typedef enum int {PLANES_OPEN, PLANES_MIXED, PLANES_EXTREME} plane_set_type;

   typedef struct packed {
      logic [SLOT_W-1:0]            slot;
      logic [AXES-1:0][BOX_W-1:0]   box_max;
      logic [AXES-1:0][BOX_W-1:0]   box_min;
      logic [AXES-1:0][CHUNK_W-1:0] chunk;
   } chunk_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int outstanding;
   int mismatches;
   int quiet_cycles = 0;
   int stall_len = 0;
   bit tx_idling = 1'b1;
   bit rx_idling = 1'b1;
   int grid_center [AXES] = '{0, 0, 0};
   int grid_r = 18;
   int i;

   always #6 clock = ~clock;

   chunk_frustum_distance_culler uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cull_checker u_cull_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   function automatic chunk_item_type make_chunk(input int x, input int y, input int z,
                                                 input int lo, input int hi,
                                                 input logic [SLOT_W-1:0] slot);
      chunk_item_type c;
      int             k;
      c.chunk[0] = x[CHUNK_W-1:0];
      c.chunk[1] = y[CHUNK_W-1:0];
      c.chunk[2] = z[CHUNK_W-1:0];
      for (k = 0; k < AXES; k++) begin
         c.box_min[k] = lo[BOX_W-1:0];
         c.box_max[k] = hi[BOX_W-1:0];
      end
      c.slot = slot;
      return c;
   endfunction

   function automatic chunk_item_type random_chunk();
      chunk_item_type c;
      int             k, off, lo, hi;
      for (k = 0; k < AXES; k++) begin
         if ($urandom_range(0, 9) < 2) begin
            c.chunk[k] = CHUNK_W'($urandom);
         end else if (k == 1) begin
            c.chunk[k] = CHUNK_W'(int'($urandom_range(0, WORLD_LAYERS + 1)) - 1);
         end else begin
            off = int'($urandom_range(0, 2 * grid_r + 4)) - (grid_r + 2);
            c.chunk[k] = CHUNK_W'(grid_center[k] + off);
         end
         if ($urandom_range(0, 9) == 0) begin
            c.box_min[k] = BOX_W'($urandom);
            c.box_max[k] = BOX_W'($urandom);
         end else begin
            lo = $urandom_range(0, CHUNK_SIZE);
            hi = $urandom_range(lo, CHUNK_SIZE);
            c.box_min[k] = BOX_W'(lo);
            c.box_max[k] = BOX_W'(hi);
         end
      end
      c.slot = $urandom;
      return c;
   endfunction

   function automatic logic [PLANE_W-1:0] rand_plane();
      int a, b, c, d;
      a = int'($urandom_range(0, 32767)) - 16384;
      b = int'($urandom_range(0, 32767)) - 16384;
      c = int'($urandom_range(0, 32767)) - 16384;
      d = int'($urandom_range(0, 8191)) - 4096;
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return {$urandom, $urandom};
         default: return {d[15:0], c[15:0], b[15:0], a[15:0]};
      endcase
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(0, 2097151)) - 1048576;
   endfunction

   task automatic offer_chunk(input chunk_item_type c, input logic drawable);
      if (tx_idling && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - $bits(chunk_item_type)){1'b0}}, c};
      req_tuser  <= drawable;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input int vd, input int cx, input int cy, input int cz,
                            input logic [CAMF_W-1:0] frac, input plane_set_type planes);
      logic [PLANE_W-1:0] pv;
      int                 p;
      wait_drained();
      for (p = 0; p < PLANES; p++) begin
         case (planes)
            PLANES_OPEN:    pv = '0;
            PLANES_EXTREME: pv = (p % 2 == 0) ? 64'h7FFF_8000_7FFF_8000
                                              : 64'h8000_7FFF_8000_7FFF;
            default:        pv = rand_plane();
         endcase
         write_reg(CSR_PLANE_LEFT + CSR_IDX_W'(p), pv);
      end
      write_reg(CSR_CAMERA_BLOCK, {1'($urandom), cz[CAM_W-1:0], cy[CAM_W-1:0], cx[CAM_W-1:0]});
      write_reg(CSR_CAMERA_FRACTION, {32'($urandom), 8'($urandom), frac});
      write_reg(CSR_VIEW_DISTANCE, {32'($urandom), 21'($urandom), vd[VD_W-1:0]});
      csr_we <= 1'b0;
      grid_center[0] = cx >>> CHUNK_SHIFT;
      grid_center[1] = cy >>> CHUNK_SHIFT;
      grid_center[2] = cz >>> CHUNK_SHIFT;
      grid_r = (vd % 2048 + CHUNK_SIZE - 1) / CHUNK_SIZE + 1;
   endtask

   task automatic run_chunks(input int count);
      repeat (count) offer_chunk(random_chunk(), $urandom_range(0, 6) != 0);
   endtask

   // result side: random stalls, or one long hold when asked
   initial begin
      bit stall_taken;
      stall_taken = 1'b0;
      forever begin
         if (stall_len > 0 && !stall_taken) begin
            rsp_tready <= 1'b0;
            repeat (stall_len) @(posedge clock);
            stall_taken = 1'b1;
         end else if (rx_idling && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: camera at origin, view distance 256, open planes
      offer_chunk(make_chunk(0, 0, 0, 0, 16, 32'h0000_0000), 1'b1);
      offer_chunk(make_chunk(16, 0, 0, 0, 16, 32'hFFFF_FFFF), 1'b1);
      offer_chunk(make_chunk(17, 3, 0, 0, 16, 32'h1111_0001), 1'b1);
      offer_chunk(make_chunk(18, 3, 0, 0, 16, 32'h1111_0002), 1'b1);
      offer_chunk(make_chunk(-17, 3, 0, 0, 16, 32'h1111_0003), 1'b1);
      offer_chunk(make_chunk(-18, 3, 0, 0, 16, 32'h1111_0004), 1'b1);
      offer_chunk(make_chunk(0, 0, 16, 0, 16, 32'h1111_0005), 1'b1);
      offer_chunk(make_chunk(0, 0, -17, 0, 16, 32'h1111_0006), 1'b1);
      offer_chunk(make_chunk(12, 0, 12, 0, 16, 32'h1111_0007), 1'b1);
      offer_chunk(make_chunk(0, -1, 0, 0, 16, 32'h1111_0008), 1'b1);
      offer_chunk(make_chunk(0, 15, 0, 0, 16, 32'h1111_0009), 1'b1);
      offer_chunk(make_chunk(0, 16, 0, 0, 16, 32'h1111_000A), 1'b1);
      offer_chunk(make_chunk(65535, 65535, 65535, 16, 16, 32'h1111_000B), 1'b1);
      offer_chunk(make_chunk(-65536, -65536, -65536, 0, 0, 32'h1111_000C), 1'b1);
      offer_chunk(make_chunk(1, 3, 1, 16, 0, 32'h1111_000D), 1'b1);
      offer_chunk(make_chunk(1, 1, 1, 31, 31, 32'h1111_000E), 1'b1);
      offer_chunk(make_chunk(-1, 2, -1, 0, 0, 32'h1111_000F), 1'b1);
      offer_chunk(make_chunk(0, 0, 0, 0, 16, 32'hAAAA_5555), 1'b0);

      configure(0, 5, 70, -3, 24'($urandom), PLANES_OPEN);
      stall_len = 60;
      run_chunks(PHASE_ITEMS);
      configure(1, rand_coord(), 40, rand_coord(), 24'($urandom), PLANES_MIXED);
      run_chunks(PHASE_ITEMS);
      configure(2047, 1048575, 0, -1048576, 24'hFF_FFFF, PLANES_EXTREME);
      run_chunks(PHASE_ITEMS);
      configure(1024, -1048576, 1048575, 1048575, 24'h00_0000, PLANES_MIXED);
      run_chunks(PHASE_ITEMS);
      configure(256, 0, 0, 0, 24'h00_0000, PLANES_OPEN);
      run_chunks(PHASE_ITEMS);
      for (i = 0; i < 4; i++) begin
         configure($urandom_range(1, 1024), rand_coord(), int'($urandom_range(0, 384)) - 64,
                   rand_coord(), 24'($urandom), PLANES_MIXED);
         run_chunks(PHASE_ITEMS);
      end
      configure($urandom_range(1, 1024), rand_coord(), int'($urandom_range(0, 384)) - 64,
                rand_coord(), 24'($urandom), PLANES_MIXED);
      tx_idling = 1'b0;
      rx_idling = 1'b0;
      run_chunks(PHASE_ITEMS);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
